// ===== hdl/sed_pkg.sv =====
// Shared types, character codes and helper functions for the string escape decoder.
`timescale 1ns / 1ps

package sed_pkg;

	localparam int CP_W  = 21;
	localparam int ACC_W = 16;
	localparam int HI_W  = 10;

	// Parse phases
	typedef enum logic [2:0] {
		PH_PLAIN  = 3'd0,
		PH_ESC    = 3'd1,
		PH_HEX1   = 3'd2,
		PH_WANTBS = 3'd3,
		PH_WANTU  = 3'd4,
		PH_HEX2   = 3'd5,
		PH_DROP   = 3'd6
	} phase_t;

	// What one character does
	typedef enum logic [1:0] {
		ACT_HOLD  = 2'd0,
		ACT_VALUE = 2'd1,
		ACT_ERROR = 2'd2
	} act_t;

	typedef struct packed {
		logic            valid;
		logic [CP_W-1:0] char_out;
		logic            is_error;
		logic            end_of_string;
	} res_t;

	localparam logic [CP_W-1:0] CH_DQUOTE = 21'h22;
	localparam logic [CP_W-1:0] CH_APOS   = 21'h27;
	localparam logic [CP_W-1:0] CH_BSLASH = 21'h5C;
	localparam logic [CP_W-1:0] CH_SLASH  = 21'h2F;
	localparam logic [CP_W-1:0] CH_B      = 21'h62;
	localparam logic [CP_W-1:0] CH_F      = 21'h66;
	localparam logic [CP_W-1:0] CH_N      = 21'h6E;
	localparam logic [CP_W-1:0] CH_R      = 21'h72;
	localparam logic [CP_W-1:0] CH_T      = 21'h74;
	localparam logic [CP_W-1:0] CH_U      = 21'h75;

	localparam logic [CP_W-1:0] CP_BS  = 21'h08;
	localparam logic [CP_W-1:0] CP_FF  = 21'h0C;
	localparam logic [CP_W-1:0] CP_LF  = 21'h0A;
	localparam logic [CP_W-1:0] CP_CR  = 21'h0D;
	localparam logic [CP_W-1:0] CP_TAB = 21'h09;

	localparam logic [CP_W-1:0]  SUPP_BASE = 21'h10000;
	localparam logic [ACC_W-1:0] HIGH_MIN  = 16'hD800;
	localparam logic [ACC_W-1:0] HIGH_MAX  = 16'hDBFF;
	localparam logic [ACC_W-1:0] LOW_MIN   = 16'hDC00;
	localparam logic [ACC_W-1:0] LOW_MAX   = 16'hDFFF;

	// {ok, value} of one hex digit, either case
	function automatic logic [4:0] hex_digit(input logic [CP_W-1:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 21'h30 && c <= 21'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic logic is_high_sur(input logic [ACC_W-1:0] v);
		return (v >= HIGH_MIN) && (v <= HIGH_MAX);
	endfunction

	function automatic logic is_low_sur(input logic [ACC_W-1:0] v);
		return (v >= LOW_MIN) && (v <= LOW_MAX);
	endfunction

endpackage

// ===== hdl/string_escape_decoder_core.sv =====
// Top level of the string escape decoder: input register, parser, result register.
`timescale 1ns / 1ps

// Unescapes a quoted string streamed one code point per transfer and gives at
// most one decoded code point per input character. The block takes one
// character every clock cycle unless the input stalls; a transferred character
// sits in the input register while the parser decodes it and updates the parse
// state, and its result (if any) is loaded into the result register when the
// character advances, so the result passes through the input register and then
// the result register before it is offered on the output. The parser's
// per-character state update sets the rate. Input stalls only when a pending result
// cannot move into a full result register. Errors deliver one result with
// is_error and end_of_string set; the remainder of that string is dropped up
// to its last character. Write quote_mode only while idle.

module string_escape_decoder_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [sed_pkg::CP_W-1:0] char_in,
	input  logic                     last_char,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [sed_pkg::CP_W-1:0] char_out,
	output logic                     is_error,
	output logic                     end_of_string
);
	import sed_pkg::*;

	logic            quote_mode_q;
	logic            valid_s1;
	logic [CP_W-1:0] char_s1;
	logic            last_s1;
	res_t            res;
	logic            free;
	logic            advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_mode_q <= 1'b0;
		end else if (cfg_we) begin
			quote_mode_q <= cfg_wdata;
		end
	end

	// Advance unless a result is pending and the result register is blocked
	assign advance  = valid_s1 && (!res.valid || free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
			last_s1 <= last_char;
		end
	end

	sed_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.char_in    (char_s1),
		.last_char  (last_s1),
		.quote_mode (quote_mode_q),
		.res        (res)
	);

	sed_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && res.valid),
		.res           (res),
		.free          (free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.char_out      (char_out),
		.is_error      (is_error),
		.end_of_string (end_of_string)
	);

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_error |-> char_out == '0 && end_of_string)
		else $error("error result with nonzero code point or open string");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && res.valid && !free)
		else $error("input stalled without a blocked result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && advance |-> !res.valid)
		else $error("result register overwritten before transfer");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.valid |=> out_valid)
		else $error("loaded result not presented");

endmodule

// ===== hdl/sed_parser.sv =====
// Escape parser: phase state, hex accumulation and per-character result decode.
`timescale 1ns / 1ps

module sed_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [sed_pkg::CP_W-1:0] char_in,
	input  logic                    last_char,
	input  logic                    quote_mode,
	output sed_pkg::res_t           res
);
	import sed_pkg::*;

	phase_t            phase_q, phase_d;
	logic [1:0]        cnt_q, cnt_d;
	logic [ACC_W-1:0]  acc_q, acc_d;
	logic [HI_W-1:0]   hi_q, hi_d;

	act_t              act;
	logic [CP_W-1:0]   val;
	logic [4:0]        hd;
	logic [ACC_W-1:0]  acc_shift;
	logic              cnt_full;

	assign hd        = hex_digit(char_in);
	assign acc_shift = {acc_q[ACC_W-5:0], hd[3:0]};
	assign cnt_full  = (cnt_q == 2'd3);

	// Output decode
	always_comb begin
		act = ACT_HOLD;
		val = '0;
		case (phase_q)
			PH_ESC: begin
				case (char_in)
					CH_DQUOTE: begin
						act = quote_mode ? ACT_ERROR : ACT_VALUE;
						val = char_in;
					end
					CH_APOS: begin
						act = quote_mode ? ACT_VALUE : ACT_ERROR;
						val = char_in;
					end
					CH_BSLASH, CH_SLASH: begin
						act = ACT_VALUE;
						val = char_in;
					end
					CH_B: begin act = ACT_VALUE; val = CP_BS;  end
					CH_F: begin act = ACT_VALUE; val = CP_FF;  end
					CH_N: begin act = ACT_VALUE; val = CP_LF;  end
					CH_R: begin act = ACT_VALUE; val = CP_CR;  end
					CH_T: begin act = ACT_VALUE; val = CP_TAB; end
					CH_U: act = last_char ? ACT_ERROR : ACT_HOLD;
					default: act = ACT_ERROR;
				endcase
			end
			PH_HEX1, PH_HEX2: begin
				if (!hd[4]) begin
					act = ACT_ERROR;
				end else if (!cnt_full) begin
					act = last_char ? ACT_ERROR : ACT_HOLD;
				end else if (phase_q == PH_HEX1) begin
					if (is_low_sur(acc_shift)) begin
						act = ACT_ERROR;
					end else if (is_high_sur(acc_shift)) begin
						act = last_char ? ACT_ERROR : ACT_HOLD;
					end else begin
						act = ACT_VALUE;
						val = {{(CP_W-ACC_W){1'b0}}, acc_shift};
					end
				end else if (!is_low_sur(acc_shift)) begin
					act = ACT_ERROR;
				end else begin
					// combine the surrogate pair
					act = ACT_VALUE;
					val = SUPP_BASE + {{(CP_W-2*HI_W){1'b0}}, hi_q, acc_shift[HI_W-1:0]};
				end
			end
			PH_WANTBS: act = (char_in != CH_BSLASH || last_char) ? ACT_ERROR : ACT_HOLD;
			PH_WANTU:  act = (char_in != CH_U || last_char) ? ACT_ERROR : ACT_HOLD;
			PH_DROP:   act = ACT_HOLD;
			default: begin
				if (char_in == CH_BSLASH) begin
					act = last_char ? ACT_ERROR : ACT_HOLD;
				end else begin
					act = ACT_VALUE;
					val = char_in;
				end
			end
		endcase
	end

	always_comb begin
		res.valid         = (act != ACT_HOLD);
		res.is_error      = (act == ACT_ERROR);
		res.char_out      = (act == ACT_ERROR) ? '0 : val;
		res.end_of_string = (act == ACT_ERROR) ? 1'b1 : last_char;
	end

	// Next state
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		hi_d    = hi_q;
		if (act == ACT_VALUE) begin
			phase_d = PH_PLAIN;
			cnt_d   = 2'd0;
			if (phase_q == PH_HEX1 || phase_q == PH_HEX2) begin
				acc_d = acc_shift;
			end
		end else if (act == ACT_ERROR) begin
			phase_d = last_char ? PH_PLAIN : PH_DROP;
			cnt_d   = 2'd0;
			acc_d   = '0;
		end else begin
			case (phase_q)
				PH_ESC, PH_WANTU: begin
					phase_d = (phase_q == PH_ESC) ? PH_HEX1 : PH_HEX2;
					cnt_d   = 2'd0;
					acc_d   = '0;
				end
				PH_HEX1, PH_HEX2: begin
					acc_d = acc_shift;
					if (!cnt_full) begin
						cnt_d = cnt_q + 2'd1;
					end else begin
						// high surrogate: wait for the second escape
						cnt_d   = 2'd0;
						hi_d    = acc_shift[HI_W-1:0];
						phase_d = PH_WANTBS;
					end
				end
				PH_WANTBS: phase_d = PH_WANTU;
				PH_DROP: begin
					if (last_char) begin
						phase_d = PH_PLAIN;
					end
				end
				default: phase_d = PH_ESC;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			cnt_q   <= 2'd0;
			acc_q   <= '0;
			hi_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			hi_q    <= hi_d;
		end
	end

endmodule

// ===== hdl/sed_out_reg.sv =====
// Result register between the parser and the output channel.
`timescale 1ns / 1ps

module sed_out_reg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  sed_pkg::res_t            res,
	output logic                     free,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [sed_pkg::CP_W-1:0] char_out,
	output logic                     is_error,
	output logic                     end_of_string
);
	import sed_pkg::*;

	logic            valid_q;
	logic [CP_W-1:0] cp_q;
	logic            err_q;
	logic            eos_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q  <= res.char_out;
			err_q <= res.is_error;
			eos_q <= res.end_of_string;
		end
	end

	assign out_valid     = valid_q;
	assign char_out      = cp_q;
	assign is_error      = err_q;
	assign end_of_string = eos_q;

endmodule

// ===== tb/sv/string_escape_decoder_core_test.sv =====
// Self-checking testbench for the string escape decoder core: directed and random strings.
`timescale 1ns / 1ps

module string_escape_decoder_core_test;
	import sed_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 6;
	localparam int SETTLE_MAX  = 5000;

	localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
	localparam logic [CP_W-1:0] DIGIT_0 = 21'h30;
	localparam logic [CP_W-1:0] LOWER_A = 21'h61;
	localparam logic [CP_W-1:0] UPPER_A = 21'h41;
	localparam logic [CP_W-1:0] LOWER_Z = 21'h7A;

	typedef struct {
		logic [CP_W-1:0] cp;
		logic            err;
		logic            eos;
	} decoded_t;

	// Ways to break an escape on purpose
	typedef enum int {
		FLAW_ESCAPE,
		FLAW_HEX,
		FLAW_LONE_LOW,
		FLAW_NO_BSLASH,
		FLAW_NO_U,
		FLAW_NOT_LOW
	} flaw_t;

	class unescape_scoreboard;
		logic             quote_mode;
		phase_t           phase;
		logic [1:0]       digit_cnt;
		logic [ACC_W-1:0] acc;
		logic [HI_W-1:0]  high_bits;
		decoded_t         expected_chars[$];
		int               errors;

		function new();
			quote_mode = 1'b0;
			phase      = PH_PLAIN;
			digit_cnt  = '0;
			acc        = '0;
			high_bits  = '0;
			errors     = 0;
		endfunction

		task report(input string msg);
			$display("mismatch at %0t ns: %s", $time, msg);
			errors++;
		endtask

		function int hex_of(input logic [CP_W-1:0] c);
			if (c >= DIGIT_0 && c < DIGIT_0 + 10) return int'(c - DIGIT_0);
			if (c >= LOWER_A && c < LOWER_A + 6) return int'(c - LOWER_A) + 10;
			if (c >= UPPER_A && c < UPPER_A + 6) return int'(c - UPPER_A) + 10;
			return -1;
		endfunction

		function void push_value(input logic [CP_W-1:0] cp, input logic fin);
			decoded_t r;
			phase     = PH_PLAIN;
			digit_cnt = '0;
			r.cp  = cp;
			r.err = 1'b0;
			r.eos = fin;
			expected_chars.push_back(r);
		endfunction

		// Reject the string: drop the rest of it unless this was its last character
		function void push_error(input logic fin);
			decoded_t r;
			phase     = fin ? PH_PLAIN : PH_DROP;
			digit_cnt = '0;
			acc       = '0;
			r.cp  = '0;
			r.err = 1'b1;
			r.eos = 1'b1;
			expected_chars.push_back(r);
		endfunction

		// Advance the parse state by one accepted character
		function void decode_char(input logic [CP_W-1:0] c, input logic fin);
			int d;
			case (phase)
				PH_ESC: begin
					case (c)
						CH_DQUOTE: if (quote_mode) push_error(fin); else push_value(c, fin);
						CH_APOS:   if (quote_mode) push_value(c, fin); else push_error(fin);
						CH_BSLASH, CH_SLASH: push_value(c, fin);
						CH_B: push_value(CP_BS, fin);
						CH_F: push_value(CP_FF, fin);
						CH_N: push_value(CP_LF, fin);
						CH_R: push_value(CP_CR, fin);
						CH_T: push_value(CP_TAB, fin);
						CH_U: begin
							if (fin) begin
								push_error(fin);
							end else begin
								phase     = PH_HEX1;
								digit_cnt = '0;
								acc       = '0;
							end
						end
						default: push_error(fin);
					endcase
				end
				PH_HEX1, PH_HEX2: begin
					d = hex_of(c);
					if (d < 0) begin
						push_error(fin);
					end else begin
						acc = {acc[11:0], d[3:0]};
						if (digit_cnt != 2'd3) begin
							digit_cnt++;
							if (fin) push_error(fin);
						end else begin
							digit_cnt = '0;
							if (phase == PH_HEX1) begin
								if (acc >= LOW_MIN && acc <= LOW_MAX) begin
									push_error(fin);
								end else if (acc >= HIGH_MIN && acc <= HIGH_MAX) begin
									if (fin) begin
										push_error(fin);
									end else begin
										high_bits = acc[HI_W-1:0];
										phase     = PH_WANTBS;
									end
								end else begin
									push_value({5'd0, acc}, fin);
								end
							end else if (!(acc >= LOW_MIN && acc <= LOW_MAX)) begin
								push_error(fin);
							end else begin
								push_value(SUPP_BASE + {1'b0, high_bits, acc[HI_W-1:0]}, fin);
							end
						end
					end
				end
				PH_WANTBS: begin
					if (c != CH_BSLASH || fin) push_error(fin);
					else phase = PH_WANTU;
				end
				PH_WANTU: begin
					if (c != CH_U || fin) begin
						push_error(fin);
					end else begin
						phase     = PH_HEX2;
						digit_cnt = '0;
						acc       = '0;
					end
				end
				PH_DROP: begin
					if (fin) phase = PH_PLAIN;
				end
				default: begin
					if (c == CH_BSLASH) begin
						if (fin) push_error(fin);
						else phase = PH_ESC;
					end else begin
						push_value(c, fin);
					end
				end
			endcase
		endfunction

		task check_char(input logic [CP_W-1:0] cp, input logic err, input logic eos);
			decoded_t e;
			if (expected_chars.size() == 0) begin
				report($sformatf("unexpected result char_out %h is_error %b end_of_string %b",
					cp, err, eos));
				return;
			end
			e = expected_chars.pop_front();
			if (cp !== e.cp) report($sformatf("char_out %h, want %h", cp, e.cp));
			if (err !== e.err) report($sformatf("is_error %b, want %b", err, e.err));
			if (eos !== e.eos) report($sformatf("end_of_string %b, want %b", eos, e.eos));
		endtask

		task check_drained();
			if (expected_chars.size() != 0)
				report($sformatf("%0d results never arrived", expected_chars.size()));
		endtask
	endclass

	logic            clk;
	logic            arst_n        = 1'b0;
	logic            cfg_we        = 1'b0;
	logic            cfg_wdata     = 1'b0;
	logic            in_valid      = 1'b0;
	logic            in_ready;
	logic [CP_W-1:0] char_in       = '0;
	logic            last_char     = 1'b0;
	logic            out_valid;
	logic            out_ready     = 1'b0;
	logic [CP_W-1:0] char_out;
	logic            is_error;
	logic            end_of_string;

	unescape_scoreboard sb;
	logic [CP_W-1:0]    text[$];
	int                 sent_chars   = 0;
	bit                 steady_input = 1'b0;
	int                 ready_hold   = 0;
	int                 ready_pick;
	int                 cycle_count;

	string_escape_decoder_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_in       (char_in),
		.last_char     (last_char),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.char_out      (char_out),
		.is_error      (is_error),
		.end_of_string (end_of_string)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	// Sample both channels before this edge's updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.decode_char(char_in, last_char);
			if (out_valid && out_ready) sb.check_char(char_out, is_error, end_of_string);
		end
	end

	// Receiver: short ready runs and short stalls mostly, now and then a long stall or a long open run
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else begin
			ready_pick = $urandom_range(0, 99);
			if (ready_pick < 55) begin
				out_ready <= 1'b1;
				ready_hold = $urandom_range(0, 4);
			end else if (ready_pick < 85) begin
				out_ready <= 1'b0;
				ready_hold = $urandom_range(0, 2);
			end else if (ready_pick < 95) begin
				out_ready <= 1'b1;
				ready_hold = $urandom_range(30, 150);
			end else begin
				out_ready <= 1'b0;
				ready_hold = $urandom_range(10, 40);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_input || r < 65) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Hold valid and payload until the transfer; keep valid high into a back-to-back item
	task automatic send_item(input logic [CP_W-1:0] c, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_in   <= c;
		last_char <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_chars++;
	endtask

	task automatic flush_text();
		int i;
		for (i = 0; i < text.size(); i++) send_item(text[i], i == text.size() - 1);
		text.delete();
	endtask

	task automatic wait_idle();
		int n;
		in_valid <= 1'b0;
		n = 0;
		while (sb.expected_chars.size() != 0 && n < SETTLE_MAX) begin
			@(posedge clk);
			n++;
		end
		// let characters that give no result clear the pipeline
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_quote_mode(input logic m);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.quote_mode = m;
	endtask

	function automatic logic [CP_W-1:0] escape_letter(input int k);
		case (k)
			0: return CH_DQUOTE;
			1: return CH_APOS;
			2: return CH_BSLASH;
			3: return CH_SLASH;
			4: return CH_B;
			5: return CH_F;
			6: return CH_N;
			7: return CH_R;
			default: return CH_T;
		endcase
	endfunction

	// Neighbors of the hex digit ranges: / : @ G ` g
	function automatic logic [CP_W-1:0] non_hex_char();
		case ($urandom_range(0, 5))
			0: return 21'h2F;
			1: return 21'h3A;
			2: return 21'h40;
			3: return 21'h47;
			4: return 21'h60;
			default: return 21'h67;
		endcase
	endfunction

	function automatic logic [CP_W-1:0] plain_char();
		logic [CP_W-1:0] c;
		case ($urandom_range(0, 9))
			0: c = $urandom_range(0, 1) ? CP_MAX : '0;
			1: c = CP_W'($urandom_range(21'hD800, 21'hDFFF));
			2, 3: c = CP_W'($urandom_range(0, CP_MAX));
			default: c = CP_W'($urandom_range(21'h20, 21'h7E));
		endcase
		if (c == CH_BSLASH) c = CH_SLASH;
		return c;
	endfunction

	function automatic logic [CP_W-1:0] bad_escape_char();
		case ($urandom_range(0, 4))
			0: return 21'h78;
			1: return 21'h55;
			2: return DIGIT_0;
			3: return LOWER_A;
			default: return plain_char();
		endcase
	endfunction

	function automatic logic [CP_W-1:0] noise_char();
		case ($urandom_range(0, 5))
			0, 1: return CH_BSLASH;
			2: return CH_U;
			3: return CP_W'(DIGIT_0 + $urandom_range(0, 9));
			4: return escape_letter($urandom_range(0, 8));
			default: return CP_W'($urandom_range(0, CP_MAX));
		endcase
	endfunction

	function automatic void add_hex4(input logic [15:0] v);
		int k;
		logic [3:0] n;
		for (k = 3; k >= 0; k--) begin
			n = v[k*4 +: 4];
			if (n < 10) text.push_back(DIGIT_0 + n);
			else if ($urandom_range(0, 1)) text.push_back(CP_W'(LOWER_A + n - 10));
			else text.push_back(CP_W'(UPPER_A + n - 10));
		end
	endfunction

	function automatic void add_escape(input logic [CP_W-1:0] c);
		text.push_back(CH_BSLASH);
		text.push_back(c);
	endfunction

	function automatic void add_unicode(input logic [15:0] v);
		add_escape(CH_U);
		add_hex4(v);
	endfunction

	function automatic void add_good_token();
		int r;
		logic [15:0] v;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			text.push_back(plain_char());
		end else if (r < 60) begin
			add_escape(escape_letter($urandom_range(0, 8)));
		end else if (r < 80) begin
			case ($urandom_range(0, 5))
				0: v = 16'h0000;
				1: v = 16'hFFFF;
				2: v = 16'hD7FF;
				3: v = 16'hE000;
				default: v = 16'($urandom_range(0, 16'hFFFF));
			endcase
			// move surrogates out of the way
			if (v >= HIGH_MIN && v <= LOW_MAX) v = v ^ 16'h8000;
			add_unicode(v);
		end else if (r < 90) begin
			add_unicode(16'($urandom_range(HIGH_MIN, HIGH_MAX)));
			add_unicode(16'($urandom_range(LOW_MIN, LOW_MAX)));
		end else begin
			add_unicode($urandom_range(0, 1) ? HIGH_MIN : HIGH_MAX);
			add_unicode($urandom_range(0, 1) ? LOW_MIN : LOW_MAX);
		end
	endfunction

	function automatic void add_bad_token();
		int good;
		logic [15:0] hi;
		logic [15:0] v;
		hi = 16'($urandom_range(HIGH_MIN, HIGH_MAX));
		case (flaw_t'($urandom_range(0, 5)))
			FLAW_ESCAPE: add_escape(bad_escape_char());
			FLAW_HEX: begin
				if ($urandom_range(0, 1)) add_unicode(hi);
				good = $urandom_range(0, 3);
				add_unicode(16'($urandom_range(0, 16'hFFFF)));
				repeat (4 - good) void'(text.pop_back());
				text.push_back(non_hex_char());
			end
			FLAW_LONE_LOW: add_unicode(16'($urandom_range(LOW_MIN, LOW_MAX)));
			FLAW_NO_BSLASH: begin
				add_unicode(hi);
				text.push_back(plain_char());
			end
			FLAW_NO_U: begin
				add_unicode(hi);
				add_escape(escape_letter($urandom_range(0, 8)));
			end
			default: begin
				add_unicode(hi);
				v = 16'($urandom_range(0, 16'hFFFF));
				if (v >= LOW_MIN && v <= LOW_MAX) v = v ^ 16'h2000;
				add_unicode(v);
			end
		endcase
	endfunction

	task automatic run_random(input int n_chars);
		int goal;
		int r;
		int cut;
		goal = sent_chars + n_chars;
		while (sent_chars < goal) begin
			steady_input = ($urandom_range(0, 9) == 0);
			r = $urandom_range(0, 99);
			if (r < 6) begin
				// loose characters, heavy on backslashes, any end marker
				repeat ($urandom_range(1, 8)) send_item(noise_char(), $urandom_range(0, 3) == 0);
			end else begin
				repeat ($urandom_range(0, 3)) add_good_token();
				if (r < 22) begin
					add_bad_token();
					repeat ($urandom_range(0, 3)) add_good_token();
				end else begin
					repeat ($urandom_range(1, 3)) add_good_token();
				end
				if (r >= 22 && r < 32 && text.size() > 1) begin
					// end the string early, often inside an escape
					cut = $urandom_range(1, text.size() - 1);
					while (text.size() > cut) void'(text.pop_back());
				end
				flush_text();
			end
		end
		steady_input = 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_quote_mode(1'b0);
		// extremes of the code point range, then a bare low surrogate
		text.push_back('0);
		text.push_back(CP_MAX);
		text.push_back(21'h0FFFFF);
		text.push_back(21'h00DC00);
		flush_text();
		// escaped quote passes, escaped apostrophe rejects, the tail is dropped
		add_escape(CH_DQUOTE);
		add_escape(CH_APOS);
		text.push_back(LOWER_Z);
		flush_text();
		add_unicode(16'hD83D);
		add_unicode(16'hDE00);
		flush_text();
		// string that ends on a backslash
		text.push_back(CH_BSLASH);
		flush_text();
		run_random(350);

		set_quote_mode(1'b1);
		add_escape(CH_APOS);
		add_escape(CH_DQUOTE);
		flush_text();
		run_random(350);

		set_quote_mode(1'b0);
		run_random(300);
		set_quote_mode(1'b1);
		run_random(100);

		wait_idle();
		sb.check_drained();
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== string_escape_decoder_core.f =====
hdl/sed_pkg.sv
hdl/sed_parser.sv
hdl/sed_out_reg.sv
hdl/string_escape_decoder_core.sv
tb/sv/string_escape_decoder_core_test.sv
